// File: hw/rtl/aras_pkg.sv
// -----------------------------------------------------------------------------
// aras_pkg - shared constants for the rotation source-address generator
// Register indexes, request codes, field widths and register reset values.
// -----------------------------------------------------------------------------
package aras_pkg;

  // configuration port
  localparam int CFG_DATA_W = 34;
  localparam int CFG_IDX_W  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X       = 4'd0,
    REG_ORIGIN_Y       = 4'd1,
    REG_STEP_X_PER_COL = 4'd2,
    REG_STEP_Y_PER_COL = 4'd3,
    REG_STEP_X_PER_ROW = 4'd4,
    REG_STEP_Y_PER_ROW = 4'd5,
    REG_SRC_WIDTH      = 4'd6,
    REG_SRC_HEIGHT     = 4'd7
  } cfg_reg_t;

  // request codes
  localparam logic REQ_TILE  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // field widths
  localparam int ORIGIN_W = 34;
  localparam int STEP_W   = 18;
  localparam int COORD_W  = 16;
  localparam int TILE_W   = 10;
  localparam int PROD_W   = 36;   // 18b signed step x 18b signed coordinate
  localparam int SUM_W    = 38;   // origin plus two products, with headroom
  localparam int RND_W    = SUM_W - 16;

  localparam int MAX_TILE_DEF = 512;

  // register reset values
  localparam logic signed [STEP_W-1:0] STEP_ONE     = 18'sd65536;
  localparam logic [COORD_W-1:0]       SRC_SIZE_RST = 16'd1024;

endpackage

// File: hw/rtl/affine_rotate_source_address.sv
// -----------------------------------------------------------------------------
// affine_rotate_source_address - inverse affine source address generator
// Maps output pixels into the source image for nearest-neighbour rotation and
// keeps the source window of the last tile request.
// -----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | in_valid, in_stall, req_type, out_x,      | in
//          | out_y, tile_w, tile_h                     |
//  result  | out_valid, out_stall, src_x, src_y, hit,  | out
//          | win_x, win_y, win_w, win_h                |
//  config  | cfg_we, cfg_index, cfg_data               | in
//
//  One transaction per clock sustained while out_stall is low; a request passes
//  from acceptance to the result register through six register stages (input,
//  multiply, add/round, clamp, min/max, result).
//  The eight multipliers in the second stage set the cycle time.
//  Each stage advances whenever it is empty or the next one is moving, so
//  bubbles close up under out_stall. Synchronous reset empties the pipeline,
//  clears the window and loads the register defaults.
//
module affine_rotate_source_address #(
  parameter int MAX_TILE = aras_pkg::MAX_TILE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,

  input  logic                              cfg_we,
  input  logic [aras_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aras_pkg::CFG_DATA_W-1:0]   cfg_data,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic [aras_pkg::COORD_W-1:0]      out_x,
  input  logic [aras_pkg::COORD_W-1:0]      out_y,
  input  logic [aras_pkg::TILE_W-1:0]       tile_w,
  input  logic [aras_pkg::TILE_W-1:0]       tile_h,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [aras_pkg::COORD_W-1:0]      src_x,
  output logic [aras_pkg::COORD_W-1:0]      src_y,
  output logic                              hit,
  output logic [aras_pkg::COORD_W-1:0]      win_x,
  output logic [aras_pkg::COORD_W-1:0]      win_y,
  output logic [aras_pkg::COORD_W-1:0]      win_w,
  output logic [aras_pkg::COORD_W-1:0]      win_h
);

  localparam int CW = aras_pkg::COORD_W;
  localparam int TW = aras_pkg::TILE_W;
  localparam int SW = aras_pkg::STEP_W;
  localparam int PW = aras_pkg::PROD_W;
  localparam int UW = aras_pkg::SUM_W;
  localparam int RW = aras_pkg::RND_W;
  localparam int TILE_MAX_CODE = (1 << TW) - 1;
  localparam logic [TW-1:0] TILE_CAP =
    (MAX_TILE > TILE_MAX_CODE) ? TW'(TILE_MAX_CODE) : TW'(MAX_TILE);

  // ---------------------------------------------------------------------------
  // configuration and window state
  // ---------------------------------------------------------------------------
  logic signed [aras_pkg::ORIGIN_W-1:0] origin_x, origin_y;
  logic signed [SW-1:0] step_x_per_col, step_y_per_col;
  logic signed [SW-1:0] step_x_per_row, step_y_per_row;
  logic [CW-1:0] src_width, src_height;
  logic [CW-1:0] window_left, window_top, window_width, window_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= '0;
      origin_y       <= '0;
      step_x_per_col <= aras_pkg::STEP_ONE;
      step_y_per_col <= '0;
      step_x_per_row <= '0;
      step_y_per_row <= aras_pkg::STEP_ONE;
      src_width      <= aras_pkg::SRC_SIZE_RST;
      src_height     <= aras_pkg::SRC_SIZE_RST;
    end else if (cfg_we) begin
      unique case (aras_pkg::cfg_reg_t'(cfg_index))
        aras_pkg::REG_ORIGIN_X:       origin_x       <= cfg_data;
        aras_pkg::REG_ORIGIN_Y:       origin_y       <= cfg_data;
        aras_pkg::REG_STEP_X_PER_COL: step_x_per_col <= cfg_data[SW-1:0];
        aras_pkg::REG_STEP_Y_PER_COL: step_y_per_col <= cfg_data[SW-1:0];
        aras_pkg::REG_STEP_X_PER_ROW: step_x_per_row <= cfg_data[SW-1:0];
        aras_pkg::REG_STEP_Y_PER_ROW: step_y_per_row <= cfg_data[SW-1:0];
        aras_pkg::REG_SRC_WIDTH:      src_width      <= cfg_data[CW-1:0];
        aras_pkg::REG_SRC_HEIGHT:     src_height     <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control
  // a stage loads when it is empty or its content moves on
  // ---------------------------------------------------------------------------
  logic a_valid, b_valid, c_valid, d_valid, e_valid;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_r;

  assign rdy_r    = !out_valid || !out_stall;
  assign rdy_e    = !e_valid || rdy_r;
  assign rdy_d    = !d_valid || rdy_e;
  assign rdy_c    = !c_valid || rdy_d;
  assign rdy_b    = !b_valid || rdy_c;
  assign rdy_a    = !a_valid || rdy_b;
  assign in_stall = !rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_a) a_valid   <= in_valid;
      if (rdy_b) b_valid   <= a_valid;
      if (rdy_c) c_valid   <= b_valid;
      if (rdy_d) d_valid   <= c_valid;
      if (rdy_e) e_valid   <= d_valid;
      if (rdy_r) out_valid <= e_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // stage A: register request, saturate tile size, form corner coordinates
  // index 0 is the top-left edge, index 1 the far edge; a pixel gets zero size
  // ---------------------------------------------------------------------------
  logic          a_type;
  logic [CW:0]   a_col [2];
  logic [CW:0]   a_row [2];
  logic [TW-1:0] tw_sat, th_sat;
  logic          req_is_tile;

  assign tw_sat      = (tile_w > TILE_CAP) ? TILE_CAP : tile_w;
  assign th_sat      = (tile_h > TILE_CAP) ? TILE_CAP : tile_h;
  assign req_is_tile = (req_type == aras_pkg::REQ_TILE);

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      a_type   <= req_type;
      a_col[0] <= {1'b0, out_x};
      a_row[0] <= {1'b0, out_y};
      a_col[1] <= (CW+1)'(out_x) + (req_is_tile ? (CW+1)'(tw_sat) : '0);
      a_row[1] <= (CW+1)'(out_y) + (req_is_tile ? (CW+1)'(th_sat) : '0);
    end
  end

  // ---------------------------------------------------------------------------
  // stage B: the eight products
  // ---------------------------------------------------------------------------
  logic                 b_type;
  logic signed [PW-1:0] b_xc [2];
  logic signed [PW-1:0] b_xr [2];
  logic signed [PW-1:0] b_yc [2];
  logic signed [PW-1:0] b_yr [2];

  always_ff @(posedge clk) begin
    if (rdy_b && a_valid) begin
      b_type <= a_type;
      for (int i = 0; i < 2; i++) begin
        b_xc[i] <= step_x_per_col * $signed({1'b0, a_col[i]});
        b_yc[i] <= step_y_per_col * $signed({1'b0, a_col[i]});
        b_xr[i] <= step_x_per_row * $signed({1'b0, a_row[i]});
        b_yr[i] <= step_y_per_row * $signed({1'b0, a_row[i]});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage C: corner sums, round half up (add one half, floor)
  // corner k uses column edge k[0]^k[1] and row edge k[1]; corner 0 is the pixel
  // ---------------------------------------------------------------------------
  localparam logic signed [UW-1:0] HALF = UW'(32768);

  logic                 c_type;
  logic signed [RW-1:0] c_rx [4];
  logic signed [RW-1:0] c_ry [4];
  logic signed [UW-1:0] sum_x [4];
  logic signed [UW-1:0] sum_y [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum_x[k] = UW'(origin_x) + UW'(b_xc[k[0] ^ k[1]]) + UW'(b_xr[k[1]]) + HALF;
      sum_y[k] = UW'(origin_y) + UW'(b_yc[k[0] ^ k[1]]) + UW'(b_yr[k[1]]) + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && b_valid) begin
      c_type <= b_type;
      for (int k = 0; k < 4; k++) begin
        c_rx[k] <= sum_x[k][UW-1:16];
        c_ry[k] <= sum_y[k][UW-1:16];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage D: clamp corners to the image, image bounds test for pixels
  // ---------------------------------------------------------------------------
  function automatic logic [CW-1:0] clamp_to(input logic signed [RW-1:0] v,
                                             input logic [CW-1:0] hi);
    if (v[RW-1]) return '0;
    else if (v > $signed({{(RW-CW){1'b0}}, hi})) return hi;
    else return v[CW-1:0];
  endfunction

  logic          d_type, d_in_img;
  logic [CW-1:0] d_cx [4];
  logic [CW-1:0] d_cy [4];
  logic          in_img;

  assign in_img = !c_rx[0][RW-1] && (c_rx[0] < $signed({{(RW-CW){1'b0}}, src_width})) &&
                  !c_ry[0][RW-1] && (c_ry[0] < $signed({{(RW-CW){1'b0}}, src_height}));

  always_ff @(posedge clk) begin
    if (rdy_d && c_valid) begin
      d_type   <= c_type;
      d_in_img <= in_img;
      for (int k = 0; k < 4; k++) begin
        d_cx[k] <= clamp_to(c_rx[k], src_width);
        d_cy[k] <= clamp_to(c_ry[k], src_height);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage E: bounding box of the clamped corners
  // ---------------------------------------------------------------------------
  function automatic logic [CW-1:0] min2(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [CW-1:0] max2(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic          e_type, e_in_img;
  logic [CW-1:0] e_minx, e_maxx, e_miny, e_maxy;

  always_ff @(posedge clk) begin
    if (rdy_e && d_valid) begin
      e_type   <= d_type;
      e_in_img <= d_in_img;
      e_minx   <= min2(min2(d_cx[0], d_cx[1]), min2(d_cx[2], d_cx[3]));
      e_maxx   <= max2(max2(d_cx[0], d_cx[1]), max2(d_cx[2], d_cx[3]));
      e_miny   <= min2(min2(d_cy[0], d_cy[1]), min2(d_cy[2], d_cy[3]));
      e_maxy   <= max2(max2(d_cy[0], d_cy[1]), max2(d_cy[2], d_cy[3]));
    end
  end

  // ---------------------------------------------------------------------------
  // result stage: window update for tiles, window test for pixels
  // the pixel point travels in e_minx/e_miny (all four corners equal it)
  // ---------------------------------------------------------------------------
  logic          out_load, is_tile, pix_hit;
  logic [CW-1:0] left_next, top_next, width_next, height_next;

  assign out_load = e_valid && rdy_r;
  assign is_tile  = (e_type == aras_pkg::REQ_TILE);

  assign left_next   = is_tile ? e_minx : window_left;
  assign top_next    = is_tile ? e_miny : window_top;
  assign width_next  = is_tile ? (e_maxx - e_minx) : window_width;
  assign height_next = is_tile ? (e_maxy - e_miny) : window_height;

  assign pix_hit = e_in_img &&
                   (e_minx >= window_left) && ((e_minx - window_left) < window_width) &&
                   (e_miny >= window_top)  && ((e_miny - window_top)  < window_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_left   <= '0;
      window_top    <= '0;
      window_width  <= '0;
      window_height <= '0;
    end else if (out_load) begin
      window_left   <= left_next;
      window_top    <= top_next;
      window_width  <= width_next;
      window_height <= height_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hit   <= !is_tile && pix_hit;
      src_x <= (!is_tile && pix_hit) ? e_minx : '0;
      src_y <= (!is_tile && pix_hit) ? e_miny : '0;
      win_x <= left_next;
      win_y <= top_next;
      win_w <= width_next;
      win_h <= height_next;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_hit_in_window: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> (src_x >= win_x) && ((src_x - win_x) < win_w) &&
                         (src_y >= win_y) && ((src_y - win_y) < win_h))
    else $error("hit reported outside the window");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> (src_x == '0) && (src_y == '0))
    else $error("miss with non-zero source address");

  a_window_hold: assert property (@(posedge clk) disable iff (rst)
    !(out_load && is_tile) |=> $stable(window_left) && $stable(window_top) &&
                               $stable(window_width) && $stable(window_height))
    else $error("window changed without a tile transaction");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb - self-checking bench for affine_rotate_source_address
// Drives tile and pixel requests through the valid/stall channel with random
// gaps and back-pressure. Predicts every result from its own copy of the warp
// registers and the stored source window. Checks each result field by field, in
// order.
// -----------------------------------------------------------------------------
module tb;
  import aras_pkg::*;

  localparam int TILE_CAP    = MAX_TILE_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOW_ERRORS = 40;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic               hit;
    logic [COORD_W-1:0] win_x;
    logic [COORD_W-1:0] win_y;
    logic [COORD_W-1:0] win_w;
    logic [COORD_W-1:0] win_h;
  } addr_result_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic                  req_type  = REQ_TILE;
  logic [COORD_W-1:0]    out_x     = '0;
  logic [COORD_W-1:0]    out_y     = '0;
  logic [TILE_W-1:0]     tile_w    = '0;
  logic [TILE_W-1:0]     tile_h    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COORD_W-1:0]    src_x, src_y, win_x, win_y, win_w, win_h;
  logic                  hit;

  // predictor copy of the warp registers and the stored window
  logic signed [ORIGIN_W-1:0] org_x, org_y;
  logic signed [STEP_W-1:0]   stp_xc, stp_yc, stp_xr, stp_yr;
  logic [COORD_W-1:0]         img_w, img_h;
  logic [COORD_W-1:0]         win_l, win_t, win_wd, win_ht;

  addr_result_t pending_addr_q[$];
  bit           calm;
  int           error_count, cycle_count, items_sent, tiles_sent, pixels_sent;
  int           hits_seen, reg_writes;

  affine_rotate_source_address dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_x     (out_x),
    .out_y     (out_y),
    .tile_w    (tile_w),
    .tile_h    (tile_h),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .src_x     (src_x),
    .src_y     (src_y),
    .hit       (hit),
    .win_x     (win_x),
    .win_y     (win_y),
    .win_w     (win_w),
    .win_h     (win_h)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 36);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic void map_point(input longint col, input longint row,
                                    output longint ix, output longint iy);
    longint sx, sy;
    sx = longint'(org_x) + longint'(stp_xc) * col + longint'(stp_xr) * row;
    sy = longint'(org_y) + longint'(stp_yc) * col + longint'(stp_yr) * row;
    // floor(v + 0.5) in Q.16
    ix = (sx + 64'sd32768) >>> 16;
    iy = (sy + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp_to(input longint v, input longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic addr_result_t predict_address(input logic rt,
                                                   input logic [COORD_W-1:0] col,
                                                   input logic [COORD_W-1:0] row,
                                                   input logic [TILE_W-1:0] tw_in,
                                                   input logic [TILE_W-1:0] th_in);
    addr_result_t r;
    longint cx [4];
    longint cy [4];
    longint tw, th, lo_x, hi_x, lo_y, hi_y, ix, iy, dx, dy;
    r = '0;
    if (rt == REQ_TILE) begin
      tw = (tw_in > TILE_CAP) ? TILE_CAP : tw_in;
      th = (th_in > TILE_CAP) ? TILE_CAP : th_in;
      map_point(col, row, cx[0], cy[0]);
      map_point(col + tw, row, cx[1], cy[1]);
      map_point(col + tw, row + th, cx[2], cy[2]);
      map_point(col, row + th, cx[3], cy[3]);
      for (int k = 0; k < 4; k++) begin
        cx[k] = clamp_to(cx[k], img_w);
        cy[k] = clamp_to(cy[k], img_h);
      end
      lo_x = cx[0]; hi_x = cx[0]; lo_y = cy[0]; hi_y = cy[0];
      for (int k = 1; k < 4; k++) begin
        if (cx[k] < lo_x) lo_x = cx[k];
        if (cx[k] > hi_x) hi_x = cx[k];
        if (cy[k] < lo_y) lo_y = cy[k];
        if (cy[k] > hi_y) hi_y = cy[k];
      end
      win_l  = lo_x[15:0];
      win_t  = lo_y[15:0];
      win_wd = COORD_W'(hi_x - lo_x);
      win_ht = COORD_W'(hi_y - lo_y);
    end else begin
      map_point(col, row, ix, iy);
      dx = ix - longint'(win_l);
      dy = iy - longint'(win_t);
      if (ix >= 0 && ix < img_w && iy >= 0 && iy < img_h &&
          dx >= 0 && dx < win_wd && dy >= 0 && dy < win_ht) begin
        r.hit   = 1'b1;
        r.src_x = ix[15:0];
        r.src_y = iy[15:0];
      end
    end
    r.win_x = win_l;
    r.win_y = win_t;
    r.win_w = win_wd;
    r.win_h = win_ht;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (error_count < SHOW_ERRORS)
      $display("tb: mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got,
               want);
    error_count++;
  endtask

  task automatic check_field(input string what, input longint got, input longint want);
    if (got != want) flag_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    addr_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_addr_q.size() == 0) begin
        flag_mismatch("unexpected transaction, src_x", src_x, 0);
      end else begin
        want = pending_addr_q.pop_front();
        check_field("src_x", src_x, want.src_x);
        check_field("src_y", src_y, want.src_y);
        check_field("hit", hit, want.hit);
        check_field("win_x", win_x, want.win_x);
        check_field("win_y", win_y, want.win_y);
        check_field("win_w", win_w, want.win_w);
        check_field("win_h", win_h, want.win_h);
        if (want.hit) hits_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  task automatic send_req(input logic rt, input logic [COORD_W-1:0] col,
                          input logic [COORD_W-1:0] row, input logic [TILE_W-1:0] tw,
                          input logic [TILE_W-1:0] th);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    out_x    <= col;
    out_y    <= row;
    tile_w   <= tw;
    tile_h   <= th;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_addr_q.push_back(predict_address(rt, col, row, tw, th));
    items_sent++;
    if (rt == REQ_TILE) tiles_sent++;
    else pixels_sent++;
  endtask

  // request channel quiet and every result back; the pipeline is then empty
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_addr_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_ORIGIN_X:       org_x  = val;
      REG_ORIGIN_Y:       org_y  = val;
      REG_STEP_X_PER_COL: stp_xc = val[STEP_W-1:0];
      REG_STEP_Y_PER_COL: stp_yc = val[STEP_W-1:0];
      REG_STEP_X_PER_ROW: stp_xr = val[STEP_W-1:0];
      REG_STEP_Y_PER_ROW: stp_yr = val[STEP_W-1:0];
      REG_SRC_WIDTH:      img_w  = val[COORD_W-1:0];
      REG_SRC_HEIGHT:     img_h  = val[COORD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  task automatic set_warp(input longint ox, input longint oy, input longint xc,
                          input longint yc, input longint xr, input longint yr,
                          input longint w, input longint h);
    write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox));
    write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
    write_reg(REG_STEP_X_PER_COL, CFG_DATA_W'(xc));
    write_reg(REG_STEP_Y_PER_COL, CFG_DATA_W'(yc));
    write_reg(REG_STEP_X_PER_ROW, CFG_DATA_W'(xr));
    write_reg(REG_STEP_Y_PER_ROW, CFG_DATA_W'(yr));
    write_reg(REG_SRC_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(h));
  endtask

  task automatic randomize_warp();
    longint sz [2];
    longint org [2];
    longint stp [4];
    for (int k = 0; k < 2; k++) begin
      case ($urandom_range(7))
        0:       sz[k] = 1;
        1:       sz[k] = 65535;
        default: sz[k] = $urandom_range(16, 1024);
      endcase
      org[k] = (longint'($urandom_range(0, sz[k])) << 16) + longint'($urandom_range(65535))
               - 32768;
      if ($urandom_range(9) == 0) org[k] = longint'({$urandom, $urandom});
    end
    for (int k = 0; k < 4; k++) begin
      stp[k] = longint'($urandom_range(0, 131072)) - 65536;
      // now and then the full 18-bit code space
      if ($urandom_range(9) == 0) stp[k] = $urandom_range(0, 262143);
    end
    set_warp(org[0], org[1], stp[0], stp[1], stp[2], stp[3], sz[0], sz[1]);
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                CFG_DATA_W'({$urandom, $urandom}));
  endtask

  // tile followed by pixels in and just around it
  task automatic run_tile_burst(input int max_side);
    logic [COORD_W-1:0] tx, ty;
    logic [TILE_W-1:0]  tw, th;
    tx = COORD_W'($urandom_range(0, 300));
    ty = COORD_W'($urandom_range(0, 300));
    tw = TILE_W'($urandom_range(1, max_side));
    th = TILE_W'($urandom_range(1, max_side));
    if ($urandom_range(19) == 0) tw = TILE_W'($urandom_range(513, 1023));
    if ($urandom_range(19) == 0) th = TILE_W'($urandom_range(513, 1023));
    send_req(REQ_TILE, tx, ty, tw, th);
    repeat ($urandom_range(3, 12))
      send_req(REQ_PIXEL, COORD_W'(tx + $urandom_range(0, tw)),
               COORD_W'(ty + $urandom_range(0, th)), TILE_W'($urandom), TILE_W'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // identity warp on a 1024 x 1024 image straight out of reset
  task automatic test_defaults();
    send_req(REQ_PIXEL, 16'd3, 16'd3, 10'h3FF, 10'h3FF);       // no window yet
    send_req(REQ_TILE, 16'd0, 16'd0, 10'd16, 10'd16);
    send_req(REQ_PIXEL, 16'd0, 16'd0, 10'd0, 10'd0);
    send_req(REQ_PIXEL, 16'd15, 16'd15, 10'd0, 10'd0);
    send_req(REQ_PIXEL, 16'd16, 16'd3, 10'd0, 10'd0);
    send_req(REQ_TILE, 16'd5, 16'd5, 10'd0, 10'd0);            // zero size tile
    send_req(REQ_PIXEL, 16'd5, 16'd5, 10'd0, 10'd0);
    send_req(REQ_TILE, 16'd1000, 16'd1000, 10'h3FF, 10'h3FF);  // saturates, clamps
    send_req(REQ_PIXEL, 16'd1023, 16'd1023, 10'd0, 10'd0);
    send_req(REQ_PIXEL, 16'd1024, 16'd1023, 10'd0, 10'd0);
    send_req(REQ_TILE, 16'hFFFF, 16'hFFFF, 10'd512, 10'd512);
    send_req(REQ_PIXEL, 16'hFFFF, 16'hFFFF, 10'h3FF, 10'h3FF);
  endtask

  // half-pixel origins: ties round up, just below a half rounds down
  task automatic test_rounding();
    wait_drained();
    write_reg(REG_ORIGIN_X, 34'h0_0000_8000);
    write_reg(REG_ORIGIN_Y, -34'sd32768);
    send_req(REQ_TILE, 16'd0, 16'd0, 10'd8, 10'd8);
    send_req(REQ_PIXEL, 16'd0, 16'd0, 10'd0, 10'd0);
    send_req(REQ_PIXEL, 16'd7, 16'd7, 10'd0, 10'd0);
    wait_drained();
    write_reg(REG_ORIGIN_X, 34'h0_0000_7FFF);
    send_req(REQ_PIXEL, 16'd0, 16'd0, 10'd0, 10'd0);
  endtask

  task automatic test_warp_extremes();
    // quarter turn on a 64 x 64 image
    wait_drained();
    set_warp(longint'(63) << 16, 0, 0, 65536, -65536, 0, 64, 64);
    send_req(REQ_TILE, 16'd0, 16'd0, 10'd64, 10'd64);
    send_req(REQ_PIXEL, 16'd10, 16'd20, 10'd0, 10'd0);
    // step codes at both ends of 18 bits, origins at both ends of 34 bits
    wait_drained();
    set_warp(34'h1_FFFF_FFFF, 34'h2_0000_0000, 18'h1FFFF, 18'h20000, -65536, 65536, 65535,
             65535);
    send_req(REQ_TILE, 16'hFFFF, 16'd0, 10'd1, 10'd1);
    send_req(REQ_PIXEL, 16'd0, 16'hFFFF, 10'd0, 10'd0);
    // empty image: corners clamp to zero and nothing hits
    wait_drained();
    set_warp(0, 0, 65536, 0, 0, 65536, 0, 0);
    send_req(REQ_TILE, 16'd0, 16'd0, 10'd4, 10'd4);
    send_req(REQ_PIXEL, 16'd0, 16'd0, 10'd0, 10'd0);
    // writes to unused indexes must leave the warp alone
    wait_drained();
    write_reg(REG_SRC_WIDTH, 34'd16);
    write_reg(REG_SRC_HEIGHT, 34'd16);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    send_req(REQ_TILE, 16'd2, 16'd2, 10'd8, 10'd8);
    send_req(REQ_PIXEL, 16'd4, 16'd4, 10'd0, 10'd0);
  endtask

  task automatic test_random_warps();
    int target;
    target = items_sent + 1050;
    while (items_sent < target) begin
      wait_drained();
      randomize_warp();
      repeat ($urandom_range(6, 12)) begin
        if ($urandom_range(99) < 85) run_tile_burst(64);
        else send_req(1'($urandom_range(1)), COORD_W'($urandom), COORD_W'($urandom),
                      TILE_W'($urandom), TILE_W'($urandom));
      end
    end
  endtask

  // back-to-back traffic with neither side idling
  task automatic test_streaming();
    int target;
    wait_drained();
    randomize_warp();
    calm   = 1'b1;
    target = items_sent + 220;
    while (items_sent < target) run_tile_burst(32);
    calm = 1'b0;
  endtask

  initial begin
    org_x  = '0;
    org_y  = '0;
    stp_xc = STEP_ONE;
    stp_yc = '0;
    stp_xr = '0;
    stp_yr = STEP_ONE;
    img_w  = SRC_SIZE_RST;
    img_h  = SRC_SIZE_RST;
    win_l  = '0;
    win_t  = '0;
    win_wd = '0;
    win_ht = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_defaults();
    test_rounding();
    test_warp_extremes();
    test_random_warps();
    test_streaming();
    wait_drained();

    $display("tb: %0d tile and %0d pixel transactions, %0d of them expected to hit",
             tiles_sent, pixels_sent, hits_seen);
    $display("tb: %0d register writes, %0d mismatches", reg_writes, error_count);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
